>>> rtl/bes_pkg.sv
// ----------------------------------------------------------------------------
// Boat Euler step package
// Shared types, constants and the CORDIC angle table.
// ----------------------------------------------------------------------------
package bes_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int TRIG_ITER_DEF  = 16;
  localparam int CORDIC_MAX     = 24;

  // Multiplier operand and product widths.
  localparam int MW = 35;
  localparam int PW = 2 * MW;

  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
  // 2^32 / (2*pi) in Q.8, split in two halves for the shared multiplier.
  localparam logic [37:0] RAD_TO_ANGLE = 38'd174992710548;
  localparam int RTA_SPLIT = 19;

  typedef enum logic [2:0] {
    REG_STEP_SIZE    = 3'd0,
    REG_INIT_X       = 3'd1,
    REG_INIT_Y       = 3'd2,
    REG_INIT_HEADING = 3'd3,
    REG_INIT_SPEED   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_RATE,
    OP_ANG_LO,
    OP_ANG_HI,
    OP_DRAG,
    OP_ACC_LO,
    OP_ACC_HI,
    OP_VX,
    OP_VY,
    OP_POS_X,
    OP_POS_Y
  } op_t;

  typedef struct packed {
    logic        start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic        done;
    logic [33:0] cos_v;
    logic [33:0] sin_v;
  } cordic_rsp_t;

  // atan(2^-i) as a binary angle, truncated.
  function automatic logic [31:0] atan_angle(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051D;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2E;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2F9;
      5'd15:   a = 32'h0000517C;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A2F;
      5'd19:   a = 32'h00000517;
      5'd20:   a = 32'h0000028B;
      5'd21:   a = 32'h00000145;
      5'd22:   a = 32'h000000A2;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/bes_if.sv
// ----------------------------------------------------------------------------
// Boat Euler step channels
// Valid/ready interfaces for the drive input and the state result.
// ----------------------------------------------------------------------------
interface bes_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] drive_one;
  logic [31:0] drive_two;

  modport source (output valid, action, drive_one, drive_two, input ready);
  modport sink   (input valid, action, drive_one, drive_two, output ready);
endinterface

interface bes_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_heading;
  logic [31:0] out_speed;
  logic        saturated;

  modport source (output valid, out_x, out_y, out_heading, out_speed, saturated,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_heading, out_speed, saturated,
                  output ready);
endinterface

>>> rtl/boat_euler_step_top.sv
// ----------------------------------------------------------------------------
// Boat Euler step top level
// One forward Euler step of a boat model per transaction, or a restart.
//
//   channel  dir  transaction
//   in_if    in   action, drive_one, drive_two
//   out_if   out  out_x, out_y, out_heading, out_speed, saturated
//   cfg_*    in   one register write per cycle with cfg_we high
//
// In an integrate step the CORDIC runs its iterations while the shared
// multiplier works through the heading and speed products; then the two velocity
// products, which wait for the CORDIC, and the two position products follow.
// Reset clears the state and control; step_size comes up as 2621.
// A finished result waits in the output register while a new transaction
// is taken; the next result waits until it has been delivered.
// ----------------------------------------------------------------------------
module boat_euler_step_top import bes_pkg::*; #(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  bes_in_if.sink        in_if,
  bes_out_if.source     out_if,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

  localparam logic signed [PW-1:0] HALF16 = PW'(1) <<< 15;
  localparam logic signed [PW-1:0] HALF30 = PW'(1) <<< 29;
  localparam logic signed [PW-1:0] HALFF  = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] DLIM   = PW'(1) <<< 47;
  localparam logic signed [PW-1:0] I32MAX = PW'(32'h7FFF_FFFF);
  localparam logic signed [PW-1:0] I32MIN = -(PW'(1) <<< 31);

  function automatic logic ovf32(input logic signed [PW-1:0] v);
    return (v > I32MAX) || (v < I32MIN);
  endfunction

  function automatic logic [31:0] clip32(input logic signed [PW-1:0] v);
    logic [31:0] c;
    if (v > I32MAX) c = 32'h7FFF_FFFF;
    else if (v < I32MIN) c = 32'h8000_0000;
    else c = v[31:0];
    return c;
  endfunction

  // Configuration registers.
  logic [15:0] step_r;
  logic [31:0] init_x_r, init_y_r, init_head_r, init_spd_r;

  // Boat state and the values of the step in progress.
  logic [31:0] px_r, py_r, hd_r, sp_r;
  logic [31:0] new_x_r, new_y_r, new_head_r, new_spd_r;
  logic [31:0] u1_r, u2_r;
  logic [MW-1:0] r_r, vx_r, vy_r;
  logic [63:0] acc_r;
  logic [48:0] der_r;
  logic        sat_r;

  state_t state_r, state_nxt;
  op_t    op_r;
  logic   phase_r;

  logic        out_valid_r;
  logic [31:0] out_x_r, out_y_r, out_head_r, out_spd_r;
  logic        out_sat_r;

  cordic_req_t cr_req;
  cordic_rsp_t cr_rsp;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  logic        in_acc;
  logic        out_free;
  logic signed [MW-1:0] h_s, sp_s, diff_s, mag_s;
  logic [32:0] sp_ext, diff_ext;
  logic signed [PW-1:0] rnd16, rnd30, rndf, drag, tot, nsum, xsum, ysum;
  logic [63:0] ang_sum, ang_sh;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 16'd2621;
      init_x_r    <= '0;
      init_y_r    <= '0;
      init_head_r <= '0;
      init_spd_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_SIZE:    step_r      <= cfg_wdata[15:0];
        REG_INIT_X:       init_x_r    <= cfg_wdata;
        REG_INIT_Y:       init_y_r    <= cfg_wdata;
        REG_INIT_HEADING: init_head_r <= cfg_wdata;
        REG_INIT_SPEED:   init_spd_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cr_req.start = in_acc && !in_if.action;
  assign cr_req.angle = hd_r;

  bes_cordic #(.ITERS(TRIG_ITERATIONS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cr_req),
    .rsp   (cr_rsp)
  );

  bes_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  // Operand selection for the shared multiplier.
  assign h_s      = $signed({{(MW-16){1'b0}}, step_r});
  assign sp_ext   = {sp_r[31], sp_r};
  assign sp_s     = $signed({{(MW-33){sp_r[31]}}, sp_ext});
  assign diff_ext = {u1_r[31], u1_r} - {u2_r[31], u2_r};
  assign diff_s   = $signed({{(MW-33){diff_ext[32]}}, diff_ext});
  assign mag_s    = sp_ext[32] ? -sp_s : sp_s;

  always_comb begin
    mul_a = h_s;
    mul_b = diff_s;
    case (op_r)
      OP_RATE:   begin mul_a = h_s; mul_b = diff_s; end
      OP_ANG_LO: begin
        mul_a = $signed(r_r);
        mul_b = $signed({{(MW-RTA_SPLIT){1'b0}}, RAD_TO_ANGLE[RTA_SPLIT-1:0]});
      end
      OP_ANG_HI: begin
        mul_a = $signed(r_r);
        mul_b = $signed({{(MW-RTA_SPLIT){1'b0}}, RAD_TO_ANGLE[37:RTA_SPLIT]});
      end
      OP_DRAG:   begin mul_a = mag_s; mul_b = sp_s; end
      OP_ACC_LO: begin mul_a = h_s; mul_b = $signed({{(MW-24){1'b0}}, der_r[23:0]}); end
      OP_ACC_HI: begin mul_a = h_s; mul_b = $signed({{(MW-25){der_r[48]}}, der_r[48:24]}); end
      OP_VX:     begin mul_a = sp_s; mul_b = $signed({cr_rsp.cos_v[33], cr_rsp.cos_v}); end
      OP_VY:     begin mul_a = sp_s; mul_b = $signed({cr_rsp.sin_v[33], cr_rsp.sin_v}); end
      OP_POS_X:  begin mul_a = h_s; mul_b = $signed(vx_r); end
      OP_POS_Y:  begin mul_a = h_s; mul_b = $signed(vy_r); end
      default:   ;
    endcase
  end

  // Rescaling of the registered product; every shift rounds half up.
  assign rnd16   = (mul_p + HALF16) >>> 16;
  assign rnd30   = (mul_p + HALF30) >>> 30;
  assign rndf    = (mul_p + HALFF) >>> FRAC_BITS;
  assign ang_sum = acc_r + (mul_p[63:0] << RTA_SPLIT) + (64'd1 << (FRAC_BITS + 7));
  assign ang_sh  = ang_sum >> (FRAC_BITS + 8);
  assign drag    = $signed({{(PW-32){u1_r[31]}}, u1_r}) +
                   $signed({{(PW-32){u2_r[31]}}, u2_r}) - rndf;
  assign tot     = (mul_p <<< 24) + $signed({{(PW-64){1'b0}}, acc_r});
  assign nsum    = $signed({{(PW-32){sp_r[31]}}, sp_r}) + ((tot + HALF16) >>> 16);
  assign xsum    = $signed({{(PW-32){px_r[31]}}, px_r}) + rnd16;
  assign ysum    = $signed({{(PW-32){py_r[31]}}, py_r}) + rnd16;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = in_if.action ? ST_DONE : ST_RUN;
      end
      ST_RUN: begin
        if (phase_r && op_r == OP_POS_Y) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      op_r    <= OP_RATE;
    end else if (in_acc) begin
      phase_r <= 1'b0;
      op_r    <= OP_RATE;
    end else if (state_r == ST_RUN) begin
      if (!phase_r) begin
        // Velocity products wait for the CORDIC.
        if (op_r != OP_VX || cr_rsp.done) phase_r <= 1'b1;
      end else begin
        phase_r <= 1'b0;
        if (op_r != OP_POS_Y) op_r <= op_t'(op_r + 4'd1);
      end
    end
  end

  // Datapath registers of the step in progress.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      u1_r  <= in_if.drive_one;
      u2_r  <= in_if.drive_two;
      sat_r <= 1'b0;
      if (in_if.action) begin
        new_x_r    <= init_x_r;
        new_y_r    <= init_y_r;
        new_head_r <= init_head_r;
        new_spd_r  <= init_spd_r;
      end
    end else if (state_r == ST_RUN && phase_r) begin
      case (op_r)
        OP_RATE:   r_r <= rnd16[MW-1:0];
        OP_ANG_LO: acc_r <= mul_p[63:0];
        OP_ANG_HI: new_head_r <= hd_r + ang_sh[31:0];
        OP_DRAG: begin
          if (drag > DLIM) begin
            der_r <= DLIM[48:0];
            sat_r <= 1'b1;
          end else if (drag < -DLIM) begin
            der_r <= -DLIM[48:0];
            sat_r <= 1'b1;
          end else begin
            der_r <= drag[48:0];
          end
        end
        OP_ACC_LO: acc_r <= mul_p[63:0];
        OP_ACC_HI: begin
          new_spd_r <= clip32(nsum);
          if (ovf32(nsum)) sat_r <= 1'b1;
        end
        OP_VX:     vx_r <= rnd30[MW-1:0];
        OP_VY:     vy_r <= rnd30[MW-1:0];
        OP_POS_X: begin
          new_x_r <= clip32(xsum);
          if (ovf32(xsum)) sat_r <= 1'b1;
        end
        OP_POS_Y: begin
          new_y_r <= clip32(ysum);
          if (ovf32(ysum)) sat_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // State commit and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r        <= '0;
      py_r        <= '0;
      hd_r        <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      px_r        <= new_x_r;
      py_r        <= new_y_r;
      hd_r        <= new_head_r;
      sp_r        <= new_spd_r;
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_x_r    <= new_x_r;
      out_y_r    <= new_y_r;
      out_head_r <= new_head_r;
      out_spd_r  <= new_spd_r;
      out_sat_r  <= sat_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.out_x       = out_x_r;
  assign out_if.out_y       = out_y_r;
  assign out_if.out_heading = out_head_r;
  assign out_if.out_speed   = out_spd_r;
  assign out_if.saturated   = out_sat_r;

endmodule

>>> rtl/bes_cordic.sv
// ----------------------------------------------------------------------------
// Boat Euler step CORDIC
// Iterative rotation-mode CORDIC giving cosine and sine in Q4.30.
// ----------------------------------------------------------------------------
module bes_cordic import bes_pkg::*; #(
  parameter int ITERS = TRIG_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cordic_req_t req,
  output cordic_rsp_t rsp
);

  localparam int N  = (ITERS > CORDIC_MAX) ? CORDIC_MAX : ITERS;
  localparam int CW = $clog2(N + 1);

  logic signed [33:0] x_r, y_r, z_r;
  logic               flip_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;

  logic               flip;
  logic [31:0]        fold;
  logic [31:0]        quad;
  logic signed [33:0] dx, dy, da;

  assign quad = req.angle + 32'h4000_0000;
  assign flip = quad[31];
  assign fold = flip ? (req.angle ^ 32'h8000_0000) : req.angle;
  assign dx   = y_r >>> cnt_r;
  assign dy   = x_r >>> cnt_r;
  assign da   = $signed({2'b00, atan_angle(5'(cnt_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == CW'(N)) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= CORDIC_START;
      y_r    <= '0;
      z_r    <= $signed({{2{fold[31]}}, fold});
      flip_r <= flip;
      cnt_r  <= '0;
    end else if (busy_r && cnt_r != CW'(N)) begin
      if (!z_r[33]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - da;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + da;
      end
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.cos_v = flip_r ? -x_r : x_r;
  assign rsp.sin_v = flip_r ? -y_r : y_r;

endmodule

>>> rtl/bes_mul.sv
// ----------------------------------------------------------------------------
// Boat Euler step multiplier
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module bes_mul import bes_pkg::*; (
  input  logic                 clk,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic signed [PW-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

>>> bench/bes_checker.sv
// ----------------------------------------------------------------------------
// Boat Euler step checker
// Watches the register port and both channels, predicts every result from
// its own copy of the boat state, and compares it field by field.
// ----------------------------------------------------------------------------
module bes_checker import bes_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bes_in_if           in_mon,
  bes_out_if          out_mon,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          err_count,
  output int          pending,
  output int          n_checked,
  output int          n_restart,
  output int          n_clamped
);

  localparam int TRIG_STEPS = (TRIG_ITER_DEF > CORDIC_MAX) ? CORDIC_MAX : TRIG_ITER_DEF;
  localparam longint BOAT_MIN = -64'sd2147483648;
  localparam longint BOAT_MAX = 64'sd2147483647;
  localparam longint DRAG_LIM = 64'sd1 <<< 47;
  localparam logic [63:0] RAD_TO_BAM = 64'd174992710548;

  localparam logic [31:0] ATAN_BAM [CORDIC_MAX] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] heading;
    logic [31:0] speed;
    logic        sat;
  } boat_state_t;

  logic [15:0] step_size;
  logic [31:0] init_x, init_y, init_heading, init_speed;
  logic [31:0] pos_x, pos_y, head, spd;
  boat_state_t expected_states [$];

  // Round to nearest, ties toward +infinity.
  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi,
                                  inout logic sat);
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    return v;
  endfunction

  function automatic boat_state_t advance_boat(input logic act, input logic [31:0] d1,
                                               input logic [31:0] d2);
    boat_state_t r;
    logic        flip, sat;
    logic [31:0] w, dang;
    logic [63:0] ang_prod;
    longint      h, u1, u2, px, py, sp, z, cx, cy, dx, dy, vx, vy, nx, ny, rate, mag, der, ns;
    sat = 1'b0;
    if (act) begin
      pos_x = init_x;
      pos_y = init_y;
      head  = init_heading;
      spd   = init_speed;
    end else begin
      h  = longint'({48'd0, step_size});
      u1 = longint'(signed'(d1));
      u2 = longint'(signed'(d2));
      px = longint'(signed'(pos_x));
      py = longint'(signed'(pos_y));
      sp = longint'(signed'(spd));
      // Fold the heading into the right half plane, then rotate.
      flip = 1'((head + 32'h40000000) >> 31);
      w  = flip ? (head ^ 32'h80000000) : head;
      z  = longint'(signed'(w));
      cx = 64'sd652032874;
      cy = 0;
      for (int i = 0; i < TRIG_STEPS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx -= dx; cy += dy; z -= longint'({32'd0, ATAN_BAM[i]});
        end else begin
          cx += dx; cy -= dy; z += longint'({32'd0, ATAN_BAM[i]});
        end
      end
      if (flip) begin
        cx = -cx;
        cy = -cy;
      end
      vx = rnd_shift(sp * cx, 30);
      vy = rnd_shift(sp * cy, 30);
      nx = clip(px + rnd_shift(h * vx, 16), BOAT_MIN, BOAT_MAX, sat);
      ny = clip(py + rnd_shift(h * vy, 16), BOAT_MIN, BOAT_MAX, sat);
      rate = rnd_shift(h * (u1 - u2), 16);
      ang_prod = 64'(rate) * RAD_TO_BAM + (64'd1 << 23);
      dang = ang_prod[55:24];
      mag = (sp < 0) ? -sp : sp;
      der = clip((u1 + u2) - rnd_shift(mag * sp, 16), -DRAG_LIM, DRAG_LIM, sat);
      ns  = clip(sp + rnd_shift(h * der, 16), BOAT_MIN, BOAT_MAX, sat);
      pos_x = nx[31:0];
      pos_y = ny[31:0];
      head  = head + dang;
      spd   = ns[31:0];
    end
    r.x = pos_x;
    r.y = pos_y;
    r.heading = head;
    r.speed = spd;
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    boat_state_t e;
    if (!rst_n) begin
      step_size <= 16'd2621;
      init_x <= '0; init_y <= '0; init_heading <= '0; init_speed <= '0;
      pos_x = '0; pos_y = '0; head = '0; spd = '0;
      expected_states.delete();
      err_count <= 0; n_checked <= 0; n_restart <= 0; n_clamped <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_SIZE:    step_size    <= cfg_wdata[15:0];
          REG_INIT_X:       init_x       <= cfg_wdata;
          REG_INIT_Y:       init_y       <= cfg_wdata;
          REG_INIT_HEADING: init_heading <= cfg_wdata;
          REG_INIT_SPEED:   init_speed   <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_states.push_back(advance_boat(in_mon.action, in_mon.drive_one,
                                               in_mon.drive_two));
        if (in_mon.action) n_restart <= n_restart + 1;
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_states.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h hd=%h sp=%h sat=%b", $time,
                   out_mon.out_x, out_mon.out_y, out_mon.out_heading,
                   out_mon.out_speed, out_mon.saturated);
          err_count <= err_count + 1;
        end else begin
          e = expected_states.pop_front();
          n_checked <= n_checked + 1;
          if (e.sat) n_clamped <= n_clamped + 1;
          if (out_mon.out_x !== e.x || out_mon.out_y !== e.y ||
              out_mon.out_heading !== e.heading || out_mon.out_speed !== e.speed ||
              out_mon.saturated !== e.sat) begin
            $display("%0t: mismatch expected x=%h y=%h hd=%h sp=%h sat=%b", $time,
                     e.x, e.y, e.heading, e.speed, e.sat);
            $display("%0t:          actual   x=%h y=%h hd=%h sp=%h sat=%b", $time,
                     out_mon.out_x, out_mon.out_y, out_mon.out_heading,
                     out_mon.out_speed, out_mon.saturated);
            err_count <= err_count + 1;
          end
        end
      end
    end
    pending <= expected_states.size();
  end

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Boat Euler step testbench
// Directed corner transactions, then random phases under several register
// settings, with bursty input and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_top;
  import bes_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam logic ACT_STEP = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          err_count, pending, n_checked, n_restart, n_clamped;
  int          idle_cycles, n_settings, burst_left;
  logic        hold_req;

  bes_in_if  in_ch ();
  bes_out_if out_ch ();

  boat_euler_step_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch), .out_if(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  bes_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .err_count(err_count), .pending(pending), .n_checked(n_checked),
    .n_restart(n_restart), .n_clamped(n_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result receiver: switches between stall patterns.
  initial begin
    int mode, left, hold;
    logic held;
    mode = 0; left = 0; hold = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        hold = LONG_HOLD;
        held = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = 64;
        end
        left--;
        case (mode)
          0, 1:    out_ch.ready <= 1'b1;
          2:       out_ch.ready <= ($urandom_range(0, 1) == 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("boat_euler_step_top regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Withdraws the offered transaction, then waits for every result.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic load_settings(input logic [15:0] h, input logic [31:0] x0,
                               input logic [31:0] y0, input logic [31:0] a0,
                               input logic [31:0] v0);
    wait_drained();
    write_reg(REG_STEP_SIZE, {16'd0, h});
    write_reg(REG_INIT_X, x0);
    write_reg(REG_INIT_Y, y0);
    write_reg(REG_INIT_HEADING, a0);
    write_reg(REG_INIT_SPEED, v0);
    n_settings++;
  endtask

  // Offers one transaction, with a random gap when a burst runs out.
  task automatic send_drive(input logic act, input logic [31:0] d1, input logic [31:0] d2);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.drive_one <= d1;
    in_ch.drive_two <= d2;
    @(posedge clk iff (in_ch.valid && in_ch.ready));
  endtask

  function automatic logic [31:0] rand_drive();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'(signed'($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
      4, 5, 6:    return 32'(signed'($urandom_range(0, 32'h3FFFFFF)) - 32'sh2000000);
      7:          return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default:    return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_speed();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      default: return 32'(signed'($urandom_range(0, 32'h3FFFFF)) - 32'sh200000);
    endcase
  endfunction

  initial begin
    logic [15:0] h;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_STEP_SIZE;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_STEP;
    in_ch.drive_one = '0;
    in_ch.drive_two = '0;
    hold_req = 1'b0;
    n_settings = 1;
    burst_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: default registers first, then the extremes and quadrant-edge headings.
    send_drive(ACT_STEP, 32'h0, 32'h0);
    send_drive(ACT_STEP, 32'h7FFFFFFF, 32'h80000000);
    send_drive(ACT_STEP, 32'h80000000, 32'h7FFFFFFF);
    send_drive(ACT_STEP, 32'h80000000, 32'h80000000);
    send_drive(ACT_RESTART, 32'hFFFFFFFF, 32'h12345678);
    load_settings(16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 32'hC0000000, 32'h7FFFFFFF);
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    send_drive(ACT_RESTART, 32'h0, 32'h0);
    send_drive(ACT_STEP, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_drive(ACT_STEP, 32'h80000000, 32'h80000000);
    send_drive(ACT_STEP, 32'h0, 32'h0);
    load_settings(16'h0, 32'h80000000, 32'h7FFFFFFF, 32'h40000000, 32'h80000000);
    send_drive(ACT_RESTART, 32'h0, 32'h0);
    send_drive(ACT_STEP, 32'h7FFFFFFF, 32'h80000000);
    load_settings(16'd2621, 32'h0, 32'h0, 32'h80000000, 32'h00010000);
    send_drive(ACT_RESTART, 32'h0, 32'h0);
    send_drive(ACT_STEP, 32'h00010000, 32'h0);
    load_settings(16'd2621, 32'h0, 32'h0, 32'h3FFFFFFF, 32'hFFFF0000);
    send_drive(ACT_RESTART, 32'h0, 32'h0);
    send_drive(ACT_STEP, 32'h0, 32'h00010000);
    load_settings(16'd1, 32'h0, 32'h0, 32'hBFFFFFFF, 32'h00800000);
    send_drive(ACT_RESTART, 32'h0, 32'h0);
    send_drive(ACT_STEP, 32'h0, 32'h0);

    // Random phases, each under its own register setting.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       h = 16'h0;
        1:       h = 16'hFFFF;
        default: h = 16'($urandom_range(0, 16'hFFFF));
      endcase
      load_settings(h, $urandom(), $urandom(), $urandom(), rand_speed());
      if (p == 2) hold_req = 1'b1;
      for (int k = 0; k < 200; k++) begin
        if ($urandom_range(0, 9) == 0)
          send_drive(ACT_RESTART, $urandom(), $urandom());
        else
          send_drive(ACT_STEP, rand_drive(), rand_drive());
      end
    end

    wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (40) @(posedge clk);
    $display("Checked %0d results (%0d restarts, %0d clamped) under %0d register settings.",
             n_checked, n_restart, n_clamped, n_settings);
    if (err_count == 0) begin
      $display("boat_euler_step_top regression: pass");
    end else begin
      $display("boat_euler_step_top regression: fail");
    end
    $finish;
  end

endmodule

>>> boat_euler_step_top.f
rtl/bes_pkg.sv
rtl/bes_if.sv
rtl/bes_cordic.sv
rtl/bes_mul.sv
rtl/boat_euler_step_top.sv
bench/bes_checker.sv
bench/tb_top.sv
